// ----- design/three_key_gesture_classifier_core_macros.svh -----
// assertion helpers for the gesture classifier core
`ifndef THREE_KEY_GESTURE_CLASSIFIER_CORE_MACROS_SVH
`define THREE_KEY_GESTURE_CLASSIFIER_CORE_MACROS_SVH

// clocked check, off while reset is high
`define TKG_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// clocked check that also runs during reset
`define TKG_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ----- design/tkg_pkg.sv -----
package tkg_pkg;

   localparam int COUNT_WIDTH = 16;
   localparam int CFG_WIDTH   = 16;
   localparam int CMP_WIDTH   = (COUNT_WIDTH > CFG_WIDTH) ? COUNT_WIDTH : CFG_WIDTH;
   localparam int PERIOD_WIDTH = 7;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_WIDTH  = 1;
   localparam int QCNT_WIDTH  = 2;
   localparam int CSR_ADDR_WIDTH = 4;
   localparam int CSR_DATA_WIDTH = 32;

   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

   typedef enum logic [2:0] {
      EVT_NONE        = 3'd0,
      EVT_LEFT_CLICK  = 3'd1,
      EVT_LEFT_LONG   = 3'd2,
      EVT_MID_CLICK   = 3'd3,
      EVT_MID_DOUBLE  = 3'd4,
      EVT_MID_LONG    = 3'd5,
      EVT_RIGHT_CLICK = 3'd6,
      EVT_RIGHT_LONG  = 3'd7
   } event_type;

   typedef enum logic [1:0] {
      REP_NONE  = 2'd0,
      REP_LEFT  = 2'd1,
      REP_RIGHT = 2'd2
   } repeat_type;

   typedef enum logic [1:0] {
      CSR_PRESS_TICKS  = 2'd0,
      CSR_LONG_TICKS   = 2'd1,
      CSR_DOUBLE_GAP   = 2'd2,
      CSR_REPEAT_PER   = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [CFG_WIDTH-1:0]    press_ticks;
      logic [CFG_WIDTH-1:0]    long_press_ticks;
      logic [CFG_WIDTH-1:0]    double_click_gap;
      logic [PERIOD_WIDTH-1:0] repeat_period;
   } cfg_type;

   typedef struct packed {
      logic [2:0] event_code;
      logic [1:0] repeat_code;
   } word_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
      sat_inc = (v == COUNT_MAX) ? COUNT_MAX : v + COUNT_WIDTH'(1);
   endfunction

   function automatic logic [CMP_WIDTH-1:0] ext_cnt(input logic [COUNT_WIDTH-1:0] v);
      ext_cnt = CMP_WIDTH'(v);
   endfunction

   function automatic logic [CMP_WIDTH-1:0] ext_cfg(input logic [CFG_WIDTH-1:0] v);
      ext_cfg = CMP_WIDTH'(v);
   endfunction

endpackage

// ----- design/three_key_gesture_classifier_core.sv -----
// latency: a tick taken at one edge shows its word on rsp_ ports the cycle after if the queue was empty
// throughput: one tick per cycle while req_stall is low; the classifier state updates in a single step
// a two-word queue sits before rsp_; req_stall rises only while it is full
// reset (synchronous, active high) clears counters, flags, queue and csr defaults
`include "three_key_gesture_classifier_core_macros.svh"

module three_key_gesture_classifier_core import tkg_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic                      req_left_down,
   input  logic                      req_middle_down,
   input  logic                      req_right_down,
   input  logic                      req_suppress_request,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [2:0]                rsp_event_code,
   output logic [1:0]                rsp_repeat_code,
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                      csr_pready
);

   cfg_type          cfg_ff, cfg_in;
   logic             accept;
   logic             push;
   word_type         push_word;
   word_type         pop_word;
   queue_status_type qstat;
   logic             csr_write;
   csr_index_type    csr_index;
   logic             word_mixed;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite;
   assign csr_index  = csr_index_type'(csr_paddr[3:2]);

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_PRESS_TICKS: cfg_in.press_ticks      = csr_pwdata[CFG_WIDTH-1:0];
            CSR_LONG_TICKS:  cfg_in.long_press_ticks = csr_pwdata[CFG_WIDTH-1:0];
            CSR_DOUBLE_GAP:  cfg_in.double_click_gap = csr_pwdata[CFG_WIDTH-1:0];
            CSR_REPEAT_PER:  cfg_in.repeat_period    = csr_pwdata[PERIOD_WIDTH-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         CSR_PRESS_TICKS: csr_prdata = CSR_DATA_WIDTH'(cfg_ff.press_ticks);
         CSR_LONG_TICKS:  csr_prdata = CSR_DATA_WIDTH'(cfg_ff.long_press_ticks);
         CSR_DOUBLE_GAP:  csr_prdata = CSR_DATA_WIDTH'(cfg_ff.double_click_gap);
         CSR_REPEAT_PER:  csr_prdata = CSR_DATA_WIDTH'(cfg_ff.repeat_period);
         default:         csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.press_ticks      <= CFG_WIDTH'(3);
         cfg_ff.long_press_ticks <= CFG_WIDTH'(100);
         cfg_ff.double_click_gap <= CFG_WIDTH'(30);
         cfg_ff.repeat_period    <= PERIOD_WIDTH'(10);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // a tick may produce a word, so hold off only when the queue has no room
   assign req_stall = qstat.full;
   assign accept    = req_valid & ~req_stall;

   tkg_front u_front (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .accept           (accept),
      .left_down        (req_left_down),
      .middle_down      (req_middle_down),
      .right_down       (req_right_down),
      .suppress_request (req_suppress_request),
      .push             (push),
      .push_word        (push_word)
   );

   tkg_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_word (push_word),
      .pop_stall (rsp_stall),
      .pop_valid (rsp_valid),
      .pop_word  (pop_word),
      .status    (qstat)
   );

   assign rsp_event_code  = pop_word.event_code;
   assign rsp_repeat_code = pop_word.repeat_code;

   assign word_mixed = (rsp_event_code != EVT_NONE) && (rsp_repeat_code != REP_NONE);

   `TKG_ASSERT(a_no_push_when_full, !(push && qstat.full), "word pushed into full queue")
   `TKG_ASSERT(a_event_or_beat, rsp_valid |-> !word_mixed, "word carries both event and beat")
   `TKG_ASSERT_ALWAYS(a_empty_after_reset, reset |=> !rsp_valid && !req_stall, "queue busy after reset")

endmodule

// ----- design/tkg_front.sv -----
module tkg_front import tkg_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  cfg_type  cfg,
   input  logic     accept,
   input  logic     left_down,
   input  logic     middle_down,
   input  logic     right_down,
   input  logic     suppress_request,
   output logic     push,
   output word_type push_word
);

   logic [COUNT_WIDTH-1:0]  left_hold_ff, middle_hold_ff, right_hold_ff, middle_gap_ff;
   logic [COUNT_WIDTH-1:0]  left_hold_in, middle_hold_in, right_hold_in, middle_gap_in;
   logic [PERIOD_WIDTH-1:0] beat_count_ff, beat_count_in;
   logic [2:0]              pending_ff, pending_in;
   logic [1:0]              repeat_kind_ff, repeat_kind_in;
   logic                    beat_flag_ff, beat_flag_in;
   logic                    first_click_ff, first_click_in;
   logic [2:0]              long_flags_ff, long_flags_in;
   logic                    suppress_ff, suppress_in;
   logic                    done;
   logic                    emit;
   logic [PERIOD_WIDTH:0]   beat_sum;
   logic [CMP_WIDTH-1:0]    press_x, long_x, gap_x;

   assign press_x = ext_cfg(cfg.press_ticks);
   assign long_x  = ext_cfg(cfg.long_press_ticks);
   assign gap_x   = ext_cfg(cfg.double_click_gap);
   assign beat_sum = {1'b0, beat_count_ff} + (PERIOD_WIDTH+1)'(1);

   always_comb begin
      left_hold_in   = left_hold_ff;
      middle_hold_in = middle_hold_ff;
      right_hold_in  = right_hold_ff;
      middle_gap_in  = middle_gap_ff;
      beat_count_in  = beat_count_ff;
      pending_in     = pending_ff;
      repeat_kind_in = repeat_kind_ff;
      beat_flag_in   = beat_flag_ff;
      first_click_in = first_click_ff;
      long_flags_in  = long_flags_ff;
      suppress_in    = suppress_ff | suppress_request;
      done           = 1'b0;
      emit           = 1'b0;
      push_word      = '0;

      // middle release: first click arms the gap, second one is a double
      if (ext_cnt(middle_hold_in) > press_x && !middle_down && !long_flags_in[1]) begin
         if (first_click_in) begin
            pending_in     = suppress_in ? EVT_NONE : EVT_MID_DOUBLE;
            suppress_in    = 1'b0;
            middle_hold_in = '0;
            first_click_in = 1'b0;
            middle_gap_in  = '0;
            done           = 1'b1;
         end else begin
            first_click_in = 1'b1;
         end
      end
      if (!done && ext_cnt(middle_hold_in) > press_x && !first_click_in &&
          ext_cnt(middle_hold_in) > long_x) begin
         pending_in       = suppress_in ? EVT_NONE : EVT_MID_LONG;
         suppress_in      = 1'b0;
         middle_hold_in   = '0;
         first_click_in   = 1'b0;
         long_flags_in[1] = 1'b1;
         done             = 1'b1;
      end
      if (!done && ext_cnt(right_hold_in) > press_x && !right_down && !long_flags_in[2]) begin
         pending_in    = suppress_in ? EVT_NONE : EVT_RIGHT_CLICK;
         suppress_in   = 1'b0;
         right_hold_in = '0;
         done          = 1'b1;
      end
      if (!done) begin
         if (ext_cnt(right_hold_in) > long_x) begin
            long_flags_in[2] = 1'b1;
            pending_in       = suppress_in ? EVT_NONE : EVT_RIGHT_LONG;
            suppress_in      = 1'b0;
            right_hold_in    = '0;
         end
         if (ext_cnt(left_hold_in) > press_x && !left_down && !long_flags_in[0]) begin
            pending_in   = suppress_in ? EVT_NONE : EVT_LEFT_CLICK;
            suppress_in  = 1'b0;
            left_hold_in = '0;
            done         = 1'b1;
         end
      end
      if (!done) begin
         if (ext_cnt(left_hold_in) > long_x) begin
            long_flags_in[0] = 1'b1;
            pending_in       = suppress_in ? EVT_NONE : EVT_LEFT_LONG;
            suppress_in      = 1'b0;
            left_hold_in     = '0;
         end

         // hold counters and repeat beats
         if (left_down) begin
            left_hold_in = sat_inc(left_hold_in);
            if (pending_in == EVT_LEFT_LONG) begin
               repeat_kind_in = REP_LEFT;
               if (beat_sum >= {1'b0, cfg.repeat_period}) begin
                  beat_flag_in  = 1'b1;
                  beat_count_in = '0;
               end else begin
                  beat_count_in = beat_sum[PERIOD_WIDTH-1:0];
               end
            end
         end else begin
            left_hold_in     = '0;
            long_flags_in[0] = 1'b0;
            if (repeat_kind_in == REP_LEFT) begin
               repeat_kind_in = REP_NONE;
               beat_flag_in   = 1'b0;
               beat_count_in  = '0;
            end
         end
         if (middle_down) begin
            middle_hold_in = sat_inc(middle_hold_in);
         end else begin
            middle_hold_in   = '0;
            long_flags_in[1] = 1'b0;
         end
         if (right_down) begin
            right_hold_in = sat_inc(right_hold_in);
            if (pending_in == EVT_RIGHT_LONG) begin
               repeat_kind_in = REP_RIGHT;
               if (beat_sum >= {1'b0, cfg.repeat_period}) begin
                  beat_flag_in  = 1'b1;
                  beat_count_in = '0;
               end else begin
                  beat_count_in = beat_sum[PERIOD_WIDTH-1:0];
               end
            end
         end else begin
            right_hold_in    = '0;
            long_flags_in[2] = 1'b0;
            if (repeat_kind_in == REP_RIGHT) begin
               repeat_kind_in = REP_NONE;
               beat_flag_in   = 1'b0;
               beat_count_in  = '0;
            end
         end
         if (first_click_in && !middle_down && !long_flags_in[1]) begin
            middle_gap_in = sat_inc(middle_gap_in);
         end
         // gap ran out: single middle click, never suppressed
         if (ext_cnt(middle_gap_in) > gap_x && !long_flags_in[1]) begin
            middle_gap_in  = '0;
            first_click_in = 1'b0;
            pending_in     = EVT_MID_CLICK;
         end
      end

      // emit rule
      if ((pending_in != EVT_NONE && repeat_kind_in == REP_NONE) ||
          (repeat_kind_in != REP_NONE && beat_flag_in)) begin
         emit = 1'b1;
         beat_flag_in = 1'b0;
         if (repeat_kind_in != REP_NONE) begin
            push_word.event_code  = EVT_NONE;
            push_word.repeat_code = repeat_kind_in;
         end else begin
            push_word.event_code  = pending_in;
            push_word.repeat_code = REP_NONE;
            pending_in            = EVT_NONE;
         end
      end
   end

   assign push = accept & emit;

   always_ff @(posedge clock) begin
      if (reset) begin
         left_hold_ff   <= '0;
         middle_hold_ff <= '0;
         right_hold_ff  <= '0;
         middle_gap_ff  <= '0;
         beat_count_ff  <= '0;
         pending_ff     <= EVT_NONE;
         repeat_kind_ff <= REP_NONE;
         beat_flag_ff   <= 1'b0;
         first_click_ff <= 1'b0;
         long_flags_ff  <= '0;
         suppress_ff    <= 1'b0;
      end else if (accept) begin
         left_hold_ff   <= left_hold_in;
         middle_hold_ff <= middle_hold_in;
         right_hold_ff  <= right_hold_in;
         middle_gap_ff  <= middle_gap_in;
         beat_count_ff  <= beat_count_in;
         pending_ff     <= pending_in;
         repeat_kind_ff <= repeat_kind_in;
         beat_flag_ff   <= beat_flag_in;
         first_click_ff <= first_click_in;
         long_flags_ff  <= long_flags_in;
         suppress_ff    <= suppress_in;
      end
   end

endmodule

// ----- design/tkg_queue.sv -----
module tkg_queue import tkg_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  word_type         push_word,
   input  logic             pop_stall,
   output logic             pop_valid,
   output word_type         pop_word,
   output queue_status_type status
);

   word_type                entry_ff [QUEUE_DEPTH];
   logic [QPTR_WIDTH-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_WIDTH-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_WIDTH-1:0]   count_ff, count_in;
   logic                    pop;

   assign pop_valid    = (count_ff != '0);
   assign pop_word     = entry_ff[rd_ptr_ff];
   assign pop          = pop_valid & ~pop_stall;
   assign status.full  = (count_ff == QCNT_WIDTH'(QUEUE_DEPTH));
   assign status.empty = ~pop_valid;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_WIDTH'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QPTR_WIDTH'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QCNT_WIDTH'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_WIDTH'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_word;
      end
   end

endmodule

// ----- tb/sv/tb_three_key_gesture_classifier_core.sv -----
module tb_three_key_gesture_classifier_core;
   import tkg_pkg::*;

   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int LEFT_BIT  = 0;
   localparam int MID_BIT   = 1;
   localparam int RIGHT_BIT = 2;
   localparam logic [2:0] NO_KEYS  = 3'b000;
   localparam logic [2:0] KEY_L    = 3'b001;
   localparam logic [2:0] KEY_M    = 3'b010;
   localparam logic [2:0] KEY_R    = 3'b100;
   localparam logic [2:0] ALL_KEYS = 3'b111;

   typedef struct packed {
      logic left;
      logic middle;
      logic right;
      logic suppress;
   } key_tick_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic req_left_down = 1'b0;
   logic req_middle_down = 1'b0;
   logic req_right_down = 1'b0;
   logic req_suppress_request = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [2:0] rsp_event_code;
   logic [1:0] rsp_repeat_code;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [CSR_ADDR_WIDTH-1:0] csr_paddr = '0;
   logic [CSR_DATA_WIDTH-1:0] csr_pwdata = '0;
   logic [CSR_DATA_WIDTH-1:0] csr_prdata;
   logic csr_pready;

   three_key_gesture_classifier_core u_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_left_down        (req_left_down),
      .req_middle_down      (req_middle_down),
      .req_right_down       (req_right_down),
      .req_suppress_request (req_suppress_request),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_event_code       (rsp_event_code),
      .rsp_repeat_code      (rsp_repeat_code),
      .csr_psel             (csr_psel),
      .csr_penable          (csr_penable),
      .csr_pwrite           (csr_pwrite),
      .csr_paddr            (csr_paddr),
      .csr_pwdata           (csr_pwdata),
      .csr_prdata           (csr_prdata),
      .csr_pready           (csr_pready)
   );

   always #5 clock = ~clock;

   // classifier state mirrored by the predictor
   cfg_type                 cfg;
   logic [COUNT_WIDTH-1:0]  lt_hold, mid_hold, rt_hold, mid_gap;
   logic [15:0]             beat_cnt;
   event_type               pend_evt;
   repeat_type              rep_kind;
   logic                    beat_pending, mid_first, sup_next;
   logic [2:0]              long_held;

   key_tick_type tick_q[$];
   word_type     expected_words[$];
   key_tick_type next_tick;
   word_type     want;
   logic         word_due;
   logic         word_taken = 1'b0;
   int           send_idle_pct = 0;
   int           recv_idle_pct = 0;
   int           mismatches = 0;
   int           cycle_count = 0;
   int           ticks_queued = 0;
   logic         hold_off = 1'b0;
   bit           hold_off_go = 1'b0;

   function automatic logic [COUNT_WIDTH-1:0] hold_inc(input logic [COUNT_WIDTH-1:0] v);
      return (v == COUNT_MAX) ? v : v + COUNT_WIDTH'(1);
   endfunction

   function automatic void clear_model();
      cfg.press_ticks      = 16'd3;
      cfg.long_press_ticks = 16'd100;
      cfg.double_click_gap = 16'd30;
      cfg.repeat_period    = 7'd10;
      lt_hold = '0;
      mid_hold = '0;
      rt_hold = '0;
      mid_gap = '0;
      beat_cnt = '0;
      pend_evt = EVT_NONE;
      rep_kind = REP_NONE;
      beat_pending = 1'b0;
      mid_first = 1'b0;
      sup_next = 1'b0;
      long_held = '0;
   endfunction

   function automatic void latch_event(input event_type code);
      pend_evt = sup_next ? EVT_NONE : code;
      sup_next = 1'b0;
   endfunction

   function automatic void count_beat();
      beat_cnt = beat_cnt + 16'd1;
      if (beat_cnt >= 16'(cfg.repeat_period)) begin
         beat_pending = 1'b1;
         beat_cnt = '0;
      end
   endfunction

   function automatic void classify_tick(input logic l, input logic m, input logic r);
      if (mid_hold > cfg.press_ticks && !m && !long_held[MID_BIT]) begin
         if (mid_first) begin
            latch_event(EVT_MID_DOUBLE);
            mid_hold = '0;
            mid_first = 1'b0;
            mid_gap = '0;
            return;
         end
         mid_first = 1'b1;
      end
      if (mid_hold > cfg.press_ticks && !mid_first && mid_hold > cfg.long_press_ticks) begin
         latch_event(EVT_MID_LONG);
         mid_hold = '0;
         mid_first = 1'b0;
         long_held[MID_BIT] = 1'b1;
         return;
      end
      if (rt_hold > cfg.press_ticks && !r && !long_held[RIGHT_BIT]) begin
         latch_event(EVT_RIGHT_CLICK);
         rt_hold = '0;
         return;
      end
      if (rt_hold > cfg.long_press_ticks) begin
         long_held[RIGHT_BIT] = 1'b1;
         latch_event(EVT_RIGHT_LONG);
         rt_hold = '0;
      end
      if (lt_hold > cfg.press_ticks && !l && !long_held[LEFT_BIT]) begin
         latch_event(EVT_LEFT_CLICK);
         lt_hold = '0;
         return;
      end
      if (lt_hold > cfg.long_press_ticks) begin
         long_held[LEFT_BIT] = 1'b1;
         latch_event(EVT_LEFT_LONG);
         lt_hold = '0;
      end

      if (l) begin
         lt_hold = hold_inc(lt_hold);
         if (pend_evt == EVT_LEFT_LONG) begin
            rep_kind = REP_LEFT;
            count_beat();
         end
      end else begin
         lt_hold = '0;
         long_held[LEFT_BIT] = 1'b0;
         if (rep_kind == REP_LEFT) begin
            rep_kind = REP_NONE;
            beat_pending = 1'b0;
            beat_cnt = '0;
         end
      end
      if (m) begin
         mid_hold = hold_inc(mid_hold);
      end else begin
         mid_hold = '0;
         long_held[MID_BIT] = 1'b0;
      end
      if (r) begin
         rt_hold = hold_inc(rt_hold);
         if (pend_evt == EVT_RIGHT_LONG) begin
            rep_kind = REP_RIGHT;
            count_beat();
         end
      end else begin
         rt_hold = '0;
         long_held[RIGHT_BIT] = 1'b0;
         if (rep_kind == REP_RIGHT) begin
            rep_kind = REP_NONE;
            beat_pending = 1'b0;
            beat_cnt = '0;
         end
      end
      // gap only runs while the first middle click waits released
      if (mid_first && !m && !long_held[MID_BIT])
         mid_gap = hold_inc(mid_gap);
      if (mid_gap > cfg.double_click_gap && !long_held[MID_BIT]) begin
         mid_gap = '0;
         mid_first = 1'b0;
         pend_evt = EVT_MID_CLICK;
      end
   endfunction

   function automatic void step_tick(input key_tick_type t, output logic due, output word_type w);
      if (t.suppress)
         sup_next = 1'b1;
      classify_tick(t.left, t.middle, t.right);
      due = 1'b0;
      w = '0;
      if ((pend_evt != EVT_NONE && rep_kind == REP_NONE) ||
          (rep_kind != REP_NONE && beat_pending)) begin
         due = 1'b1;
         beat_pending = 1'b0;
         if (rep_kind != REP_NONE) begin
            w.repeat_code = rep_kind;
         end else begin
            w.event_code = pend_evt;
            pend_evt = EVT_NONE;
         end
      end
   endfunction

   task automatic report_mismatch(input string what);
      $display("mismatch at cycle %0d: %s", cycle_count, what);
      mismatches++;
   endtask

   // sender: next tick goes out once the current one is taken
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || word_taken) begin
         if (tick_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            next_tick = tick_q.pop_front();
            req_valid <= 1'b1;
            req_left_down <= next_tick.left;
            req_middle_down <= next_tick.middle;
            req_right_down <= next_tick.right;
            req_suppress_request <= next_tick.suppress;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (reset)
         rsp_stall <= 1'b0;
      else
         rsp_stall <= hold_off || ($urandom_range(99) < recv_idle_pct);
   end

   // long receiver hold-off so the output queue fills and backs up req_
   initial begin
      wait (hold_off_go);
      @(negedge clock);
      hold_off <= 1'b1;
      repeat (300) @(negedge clock);
      hold_off <= 1'b0;
   end

   always @(posedge clock) begin
      if (reset) begin
         word_taken = 1'b0;
      end else begin
         cycle_count++;
         if (cycle_count > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
         end else begin
            word_taken = req_valid && !req_stall;
            if (word_taken) begin
               step_tick({req_left_down, req_middle_down, req_right_down,
                          req_suppress_request}, word_due, want);
               if (word_due)
                  expected_words.push_back(want);
            end
            if (rsp_valid && !rsp_stall) begin
               if (expected_words.size() == 0) begin
                  report_mismatch($sformatf("unexpected word event %0d repeat %0d",
                                            rsp_event_code, rsp_repeat_code));
               end else begin
                  want = expected_words.pop_front();
                  if (rsp_event_code !== want.event_code)
                     report_mismatch($sformatf("event_code got %0d want %0d",
                                               rsp_event_code, want.event_code));
                  if (rsp_repeat_code !== want.repeat_code)
                     report_mismatch($sformatf("repeat_code got %0d want %0d",
                                               rsp_repeat_code, want.repeat_code));
               end
            end
         end
      end
   end

   task automatic write_reg(input csr_index_type idx, input logic [31:0] val);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= CSR_ADDR_WIDTH'({idx, 2'b00});
      csr_pwdata <= val;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      case (idx)
         CSR_PRESS_TICKS: cfg.press_ticks = val[15:0];
         CSR_LONG_TICKS:  cfg.long_press_ticks = val[15:0];
         CSR_DOUBLE_GAP:  cfg.double_click_gap = val[15:0];
         CSR_REPEAT_PER:  cfg.repeat_period = val[6:0];
         default: ;
      endcase
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic set_cfg(input int press, input int long_t, input int gap, input int period);
      write_reg(CSR_PRESS_TICKS, press);
      write_reg(CSR_LONG_TICKS, long_t);
      write_reg(CSR_DOUBLE_GAP, gap);
      write_reg(CSR_REPEAT_PER, period);
   endtask

   // wait until every word is out, then let the pipeline settle
   task automatic wait_quiet();
      while (tick_q.size() != 0 || req_valid || expected_words.size() != 0)
         @(posedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic queue_ticks(input logic [2:0] keys, input int n, input bit sup = 1'b0);
      key_tick_type t;
      for (int i = 0; i < n; i++) begin
         t.left = keys[0];
         t.middle = keys[1];
         t.right = keys[2];
         t.suppress = sup && (i == 0);
         tick_q.push_back(t);
      end
      ticks_queued += n;
   endtask

   task automatic queue_gesture();
      int pick, span, gap_span, n;
      logic [2:0] keys;
      bit sup;
      key_tick_type t;
      pick = $urandom_range(0, 9);
      sup = ($urandom_range(0, 7) == 0);
      span = int'(cfg.long_press_ticks) + 3 * int'(cfg.repeat_period) + 4;
      if (span > 24)
         span = 24;
      gap_span = int'(cfg.double_click_gap) + 3;
      if (gap_span > 12)
         gap_span = 12;
      case (pick)
         0: begin
            n = $urandom_range(1, 8);
            repeat (n) begin
               t = key_tick_type'(4'($urandom_range(0, 15)));
               tick_q.push_back(t);
            end
            ticks_queued += n;
         end
         1, 2: begin
            queue_ticks(KEY_M, $urandom_range(1, span), sup);
            queue_ticks(NO_KEYS, $urandom_range(0, gap_span));
            queue_ticks(KEY_M, $urandom_range(1, span));
            queue_ticks(NO_KEYS, gap_span);
         end
         9: begin
            // broken gesture: the held keys change halfway
            queue_ticks(3'($urandom_range(1, 7)), $urandom_range(1, span), sup);
            queue_ticks(3'($urandom_range(0, 7)), $urandom_range(1, span));
            queue_ticks(NO_KEYS, $urandom_range(0, gap_span));
         end
         default: begin
            keys = (pick < 8) ? (KEY_L << $urandom_range(0, 2)) : 3'($urandom_range(1, 7));
            queue_ticks(keys, $urandom_range(1, span), sup);
            queue_ticks(NO_KEYS, $urandom_range(1, gap_span));
         end
      endcase
   endtask

   task automatic queue_random(input int count);
      int stop_at;
      stop_at = ticks_queued + count;
      while (ticks_queued < stop_at)
         queue_gesture();
   endtask

   initial begin
      clear_model();
      send_idle_pct = 20;
      recv_idle_pct = 74;
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      // reset defaults: long left hold with repeat beats
      queue_ticks(KEY_L, 115);
      queue_ticks(NO_KEYS, 2);
      wait_quiet();

      set_cfg(2, 6, 4, 2);
      queue_ticks(KEY_L, 4);
      queue_ticks(NO_KEYS, 2);
      queue_ticks(KEY_R, 4);
      queue_ticks(NO_KEYS, 2);
      queue_ticks(KEY_L, 14);
      queue_ticks(NO_KEYS, 2);
      queue_ticks(KEY_R, 14);
      queue_ticks(NO_KEYS, 2);
      queue_ticks(KEY_M, 4);
      queue_ticks(NO_KEYS, 7);
      queue_ticks(KEY_M, 4);
      queue_ticks(NO_KEYS, 1);
      queue_ticks(KEY_M, 4);
      queue_ticks(NO_KEYS, 7);
      queue_ticks(KEY_M, 10);
      queue_ticks(NO_KEYS, 7);
      // hold equal to the threshold is not a click
      queue_ticks(KEY_L, 2);
      queue_ticks(NO_KEYS, 2);
      // suppressed click, then a normal one
      queue_ticks(NO_KEYS, 1, 1'b1);
      queue_ticks(KEY_L, 4);
      queue_ticks(NO_KEYS, 2);
      queue_ticks(KEY_R, 4);
      queue_ticks(NO_KEYS, 2);
      // timed-out single middle click ignores the suppress flag
      queue_ticks(KEY_M, 4, 1'b1);
      queue_ticks(NO_KEYS, 7);
      queue_ticks(KEY_R, 4);
      queue_ticks(NO_KEYS, 2);
      queue_ticks(KEY_R, 14, 1'b1);
      queue_ticks(NO_KEYS, 2);
      queue_ticks(ALL_KEYS, 5);
      queue_ticks(NO_KEYS, 8);
      queue_ticks(KEY_L, 10);
      queue_ticks(3'b101, 6);
      queue_ticks(NO_KEYS, 8);
      wait_quiet();

      set_cfg($urandom_range(0, 4), $urandom_range(1, 15), $urandom_range(1, 10),
              $urandom_range(1, 5));
      queue_random(30);
      wait_quiet();

      send_idle_pct = 74;
      recv_idle_pct = 20;
      set_cfg(0, 1, 1, 1);
      queue_random(20);
      wait_quiet();
      set_cfg($urandom_range(0, 3), $urandom_range(3, 12), $urandom_range(1, 8),
              $urandom_range(1, 4));
      queue_random(20);
      wait_quiet();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      // zero period: a beat on every tick of continued hold
      set_cfg(1, 3, 2, 0);
      queue_ticks(KEY_L, 12);
      queue_ticks(NO_KEYS, 2);
      queue_ticks(KEY_R, 12);
      queue_ticks(NO_KEYS, 2);
      queue_random(20);
      wait_quiet();

      // fast taps keep words coming while the receiver holds off
      set_cfg(0, 1, 1, 1);
      hold_off_go = 1'b1;
      repeat (8) begin
         queue_ticks(KEY_L, 1);
         queue_ticks(NO_KEYS, 1);
         queue_ticks(KEY_R, 1);
         queue_ticks(NO_KEYS, 1);
      end
      wait_quiet();

      set_cfg(1, 2, 3, 100);
      queue_ticks(KEY_L, 30);
      queue_ticks(NO_KEYS, 2);
      queue_random(10);
      wait_quiet();

      set_cfg(65535, 65535, 65535, 100);
      queue_random(10);
      wait_quiet();

      repeat (10) @(negedge clock);
      if (mismatches == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
